// ===== hw/rtl/ttc_pkg.sv =====
`timescale 1ns / 1ps
// ttc_pkg: shared types and codes for the text console core.
// Used by every module of the console; depends on nothing.
package ttc_pkg;

  typedef logic [15:0] tile_t;
  typedef logic [1:0]  cmd_t;
  typedef logic [1:0]  reg_idx_t;

  // Input transaction
  typedef struct packed {
    cmd_t       cmd;
    logic [7:0] char_code;
    logic [7:0] pos_col;
    logic [7:0] pos_row;
  } in_t;

  // Result transaction
  typedef struct packed {
    logic [6:0] cursor_col;
    logic [4:0] cursor_row;
    tile_t      tile_word;
  } out_t;

  // Configuration registers as seen by the sequencer
  typedef struct packed {
    logic [6:0] window_width;
    logic [5:0] window_height;
    tile_t      base_tile;
  } cfg_t;

  // Commands
  localparam cmd_t CMD_CHAR  = 2'd0;
  localparam cmd_t CMD_SET   = 2'd1;
  localparam cmd_t CMD_CLEAR = 2'd2;
  localparam cmd_t CMD_READ  = 2'd3;

  // Register indexes
  localparam reg_idx_t REG_WIDTH  = 2'd0;
  localparam reg_idx_t REG_HEIGHT = 2'd1;
  localparam reg_idx_t REG_BASE   = 2'd2;

  // Register reset values
  localparam logic [6:0] WIDTH_RST  = 7'd40;
  localparam logic [5:0] HEIGHT_RST = 6'd28;
  localparam tile_t      BASE_RST   = 16'd0;

  // Control characters
  localparam logic [7:0] CH_NUL = 8'h00;
  localparam logic [7:0] CH_BS  = 8'h08;
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_VT  = 8'h0B;
  localparam logic [7:0] CH_CR  = 8'h0D;

  // Tile offset of ASCII space
  localparam tile_t SPACE_CODE = 16'd32;

endpackage

// ===== hw/rtl/ttc_tile_mem.sv =====
`timescale 1ns / 1ps
// ttc_tile_mem: tile map store, one write port and one registered read port.
// Depends on ttc_pkg for the tile type.
module ttc_tile_mem #(
  parameter int DEPTH = 2048,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic           clk,
  input  logic           we,
  input  logic [AW-1:0]  waddr,
  input  ttc_pkg::tile_t wdata,
  input  logic           re,
  input  logic [AW-1:0]  raddr,
  output ttc_pkg::tile_t rdata
);

  ttc_pkg::tile_t store [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      store[waddr] <= wdata;
    end
  end

  // Read port, registered, updated only when re is high
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= store[raddr];
    end
  end

endmodule

// ===== hw/rtl/ttc_ctrl.sv =====
`timescale 1ns / 1ps
// ttc_ctrl: cursor registers and the sequencer that reads, modifies and
// writes the tile store (put, read, scroll copy, fill). Depends on ttc_pkg.
module ttc_ctrl #(
  parameter int MAX_COLS = 64,
  parameter int MAX_ROWS = 32,
  parameter int TAB_WIDTH = 8,
  localparam int AW = $clog2(MAX_COLS * MAX_ROWS)
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  output logic           busy,
  input  ttc_pkg::in_t   item,
  input  ttc_pkg::cfg_t  cfg,
  input  logic           refill,
  output logic           done,
  output ttc_pkg::out_t  result,
  output logic           mem_we,
  output logic [AW-1:0]  mem_waddr,
  output ttc_pkg::tile_t mem_wdata,
  output logic           mem_re,
  output logic [AW-1:0]  mem_raddr,
  input  ttc_pkg::tile_t mem_rdata
);

  localparam int CW    = $clog2(MAX_COLS + 1);
  localparam int RW    = $clog2(MAX_ROWS);
  localparam int HW    = $clog2(MAX_ROWS + 1);
  localparam int NSTOP = MAX_COLS / TAB_WIDTH + 1;
  localparam int SW    = $clog2(NSTOP * TAB_WIDTH + 1);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_CLEAR  = 3'd1;
  localparam logic [2:0] ST_SCROLL = 3'd2;
  localparam logic [2:0] ST_PUT    = 3'd3;
  localparam logic [2:0] ST_READ   = 3'd4;

  logic [2:0]     state, state_next;
  logic [CW-1:0]  col, col_next;
  logic [RW-1:0]  row, row_next;
  logic [AW-1:0]  ptr, ptr_next;
  ttc_pkg::tile_t fill, fill_next;
  logic [7:0]     code_q, code_next;
  logic           put_pend, put_next;
  logic           item_pend, item_next;
  logic           hit, hit_next;
  logic           fin;
  ttc_pkg::tile_t fin_tile;
  ttc_pkg::out_t  fin_res;

  logic [CW-1:0]  eff_w, col_max, set_col, tab_col;
  logic [HW-1:0]  eff_h;
  logic [RW-1:0]  row_max, set_row;
  logic [AW:0]    w_ext, h_ext, area, moved, last;
  logic [AW-1:0]  cur_addr, pos_addr;
  logic [SW-1:0]  tab_stop;
  logic           in_win;
  logic           vt_go, vt_put;
  ttc_pkg::tile_t tile_val;

  // Effective window size: zero acts as one, clamp to the store geometry
  always_comb begin
    if (cfg.window_width == '0) begin
      eff_w = CW'(1);
    end else if (int'(cfg.window_width) > MAX_COLS) begin
      eff_w = CW'(MAX_COLS);
    end else begin
      eff_w = CW'(cfg.window_width);
    end
    if (cfg.window_height == '0) begin
      eff_h = HW'(1);
    end else if (int'(cfg.window_height) > MAX_ROWS) begin
      eff_h = HW'(MAX_ROWS);
    end else begin
      eff_h = HW'(cfg.window_height);
    end
  end

  assign col_max = eff_w - CW'(1);
  assign row_max = RW'(eff_h - HW'(1));
  assign w_ext   = (AW+1)'(eff_w);
  assign h_ext   = (AW+1)'(eff_h);
  assign area    = w_ext * h_ext;
  assign moved   = area - w_ext;
  assign last    = area - (AW+1)'(1);

  // Linear addresses: row * width + col
  assign cur_addr = AW'((AW+1)'(row) * w_ext + (AW+1)'(col));
  assign pos_addr = AW'((AW+1)'(RW'(item.pos_row)) * w_ext
                        + (AW+1)'(CW'(item.pos_col)));
  assign in_win   = (9'(item.pos_col) < 9'(eff_w)) && (9'(item.pos_row) < 9'(eff_h));

  // Set cursor, clamped into the window
  assign set_col = (9'(item.pos_col) < 9'(col_max)) ? CW'(item.pos_col) : col_max;
  assign set_row = (9'(item.pos_row) < 9'(row_max)) ? RW'(item.pos_row) : row_max;

  // Next tab stop: smallest multiple of the tab width above the column
  always_comb begin
    tab_stop = SW'(NSTOP * TAB_WIDTH);
    for (int k = NSTOP; k >= 1; k--) begin
      if (k * TAB_WIDTH > int'(col)) begin
        tab_stop = SW'(k * TAB_WIDTH);
      end
    end
    tab_col = (int'(tab_stop) < int'(col_max)) ? CW'(tab_stop) : col_max;
  end

  // Glyph tile: base plus sign-extended code minus space
  assign tile_val = cfg.base_tile + {{8{code_q[7]}}, code_q} - ttc_pkg::SPACE_CODE;

  // Sequencer
  always_comb begin
    state_next = state;
    col_next   = col;
    row_next   = row;
    ptr_next   = ptr;
    fill_next  = fill;
    code_next  = code_q;
    put_next   = put_pend;
    item_next  = item_pend;
    hit_next   = hit;
    fin        = 1'b0;
    fin_tile   = '0;
    mem_we     = 1'b0;
    mem_waddr  = '0;
    mem_wdata  = '0;
    mem_re     = 1'b0;
    mem_raddr  = '0;
    vt_go      = 1'b0;
    vt_put     = 1'b0;

    unique case (state)
      ST_IDLE: begin
        if (start) begin
          code_next = item.char_code;
          unique case (item.cmd)
            ttc_pkg::CMD_SET: begin
              col_next = set_col;
              row_next = set_row;
              fin      = 1'b1;
            end
            ttc_pkg::CMD_CLEAR: begin
              col_next   = '0;
              row_next   = '0;
              ptr_next   = '0;
              fill_next  = cfg.base_tile;
              item_next  = 1'b1;
              put_next   = 1'b0;
              state_next = ST_CLEAR;
            end
            ttc_pkg::CMD_READ: begin
              mem_re     = in_win;
              mem_raddr  = pos_addr;
              hit_next   = in_win;
              state_next = ST_READ;
            end
            default: begin
              unique case (item.char_code)
                ttc_pkg::CH_NUL: fin = 1'b1;
                ttc_pkg::CH_BS: begin
                  if (col != '0) begin
                    col_next = col - CW'(1);
                  end
                  fin = 1'b1;
                end
                ttc_pkg::CH_TAB: begin
                  col_next = tab_col;
                  fin      = 1'b1;
                end
                ttc_pkg::CH_CR: begin
                  col_next = '0;
                  fin      = 1'b1;
                end
                ttc_pkg::CH_LF: begin
                  col_next = '0;
                  vt_go    = 1'b1;
                end
                ttc_pkg::CH_VT: vt_go = 1'b1;
                default: begin
                  // Lazy wrap: a cursor past the border starts a new line first
                  if (col >= eff_w) begin
                    col_next = '0;
                    vt_go    = 1'b1;
                    vt_put   = 1'b1;
                  end else begin
                    state_next = ST_PUT;
                  end
                end
              endcase

              // Row down; at the bottom row the window scrolls
              if (vt_go) begin
                if (row >= row_max) begin
                  row_next   = row_max;
                  ptr_next   = '0;
                  fill_next  = cfg.base_tile;
                  put_next   = vt_put;
                  item_next  = 1'b1;
                  state_next = ST_SCROLL;
                end else begin
                  row_next = row + RW'(1);
                  if (vt_put) begin
                    state_next = ST_PUT;
                  end else begin
                    fin = 1'b1;
                  end
                end
              end
            end
          endcase
        end
      end

      // Copy entry ptr+width to ptr; the write lands in the cycle after its read
      ST_SCROLL: begin
        mem_re    = (AW+1)'(ptr) < moved;
        mem_raddr = AW'((AW+1)'(ptr) + w_ext);
        if (ptr != '0) begin
          mem_we    = 1'b1;
          mem_waddr = ptr - AW'(1);
          mem_wdata = mem_rdata;
        end
        if ((AW+1)'(ptr) == moved) begin
          state_next = ST_CLEAR;
        end else begin
          ptr_next = ptr + AW'(1);
        end
      end

      // Fill from ptr to the end of the window
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = ptr;
        mem_wdata = fill;
        if ((AW+1)'(ptr) == last) begin
          ptr_next = '0;
          put_next = 1'b0;
          if (put_pend) begin
            state_next = ST_PUT;
          end else begin
            item_next  = 1'b0;
            fin        = item_pend;
            state_next = ST_IDLE;
          end
        end else begin
          ptr_next = ptr + AW'(1);
        end
      end

      ST_PUT: begin
        mem_we     = 1'b1;
        mem_waddr  = cur_addr;
        mem_wdata  = tile_val;
        col_next   = col + CW'(1);
        item_next  = 1'b0;
        fin        = 1'b1;
        state_next = ST_IDLE;
      end

      ST_READ: begin
        fin        = 1'b1;
        fin_tile   = hit ? mem_rdata : '0;
        state_next = ST_IDLE;
      end

      default: state_next = ST_IDLE;
    endcase
  end

  assign busy = (state != ST_IDLE);

  assign fin_res = '{cursor_col: 7'(col_next),
                     cursor_row: 5'(row_next),
                     tile_word:  fin_tile};

  // Control state; reset and geometry changes start a fill pass
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      col       <= '0;
      row       <= '0;
      ptr       <= '0;
      fill      <= ttc_pkg::BASE_RST;
      put_pend  <= 1'b0;
      item_pend <= 1'b0;
      done      <= 1'b0;
    end else if (refill) begin
      state     <= ST_CLEAR;
      col       <= '0;
      row       <= '0;
      ptr       <= '0;
      fill      <= cfg.base_tile;
      put_pend  <= 1'b0;
      item_pend <= 1'b0;
      done      <= 1'b0;
    end else begin
      state     <= state_next;
      col       <= col_next;
      row       <= row_next;
      ptr       <= ptr_next;
      fill      <= fill_next;
      put_pend  <= put_next;
      item_pend <= item_next;
      done      <= fin;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    code_q <= code_next;
    hit    <= hit_next;
    if (fin) begin
      result <= fin_res;
    end
  end

endmodule

// ===== hw/rtl/tty_text_console_core.sv =====
`timescale 1ns / 1ps
// tty_text_console_core: top level of the text console, configuration
// registers plus sequencer and tile store. Depends on ttc_pkg, ttc_ctrl, ttc_tile_mem.
//
// Usage:
//   Command channel: an item is taken when start is high and busy is low.
//   Result channel: done pulses for one cycle with result valid; every item
//   gives exactly one result unless a width or height write drops it first.
//   The receiver cannot stall, so results are never held.
//   Config channel: cfg_ready is always high; a write lands when cfg_valid is
//   high. Index 0 width, 1 height, 2 base tile; other indexes are ignored.
// Steps from accept to done, with done registered after the last step:
//   set cursor, control codes that do not scroll: done in the cycle after accept
//   printable character or tile read: the put or read state (one store access)
//   line feed at the bottom row: the scroll copy, then the fill of the bottom row,
//   then the put state with a glyph; clear window: the fill, one entry per cycle
// Throughput: one item at a time; busy drops in the cycle done shows, so the
// next item can be taken there; commands that finish in idle run every cycle
// while no fill pass holds busy high. Reset, and any write of width or height,
// fills the window, 40 x 28 at reset, with the base tile with busy held high;
// config writes are still taken during that pass.
module tty_text_console_core #(
  parameter int MAX_COLS = 64,
  parameter int MAX_ROWS = 32,
  parameter int TAB_WIDTH = 8
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  ttc_pkg::in_t        item,
  output logic                done,
  output ttc_pkg::out_t       result,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  ttc_pkg::reg_idx_t   cfg_index,
  input  logic [15:0]         cfg_data
);

  localparam int DEPTH = MAX_COLS * MAX_ROWS;
  localparam int AW    = $clog2(DEPTH);

  ttc_pkg::cfg_t  cfg_q;
  logic           refill;
  logic           mem_we, mem_re;
  logic [AW-1:0]  mem_waddr, mem_raddr;
  ttc_pkg::tile_t mem_wdata, mem_rdata;

  assign cfg_ready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_q <= '{window_width:  ttc_pkg::WIDTH_RST,
                 window_height: ttc_pkg::HEIGHT_RST,
                 base_tile:     ttc_pkg::BASE_RST};
    end else if (cfg_valid) begin
      unique case (cfg_index)
        ttc_pkg::REG_WIDTH:  cfg_q.window_width  <= cfg_data[6:0];
        ttc_pkg::REG_HEIGHT: cfg_q.window_height <= cfg_data[5:0];
        ttc_pkg::REG_BASE:   cfg_q.base_tile     <= cfg_data;
        default: ;
      endcase
    end
  end

  // A geometry change refills the store and homes the cursor
  assign refill = cfg_valid &&
                  (cfg_index == ttc_pkg::REG_WIDTH || cfg_index == ttc_pkg::REG_HEIGHT);

  ttc_ctrl #(
    .MAX_COLS (MAX_COLS),
    .MAX_ROWS (MAX_ROWS),
    .TAB_WIDTH(TAB_WIDTH)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .busy     (busy),
    .item     (item),
    .cfg      (cfg_q),
    .refill   (refill),
    .done     (done),
    .result   (result),
    .mem_we   (mem_we),
    .mem_waddr(mem_waddr),
    .mem_wdata(mem_wdata),
    .mem_re   (mem_re),
    .mem_raddr(mem_raddr),
    .mem_rdata(mem_rdata)
  );

  ttc_tile_mem #(
    .DEPTH(DEPTH)
  ) u_mem (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .re   (mem_re),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

endmodule

// ===== hw/rtl/ttc_checker.sv =====
`timescale 1ns / 1ps
// ttc_checker: port-level assertions for the text console core, bound to
// tty_text_console_core. Depends on ttc_pkg.
module ttc_checker (
  input logic              clk,
  input logic              rst,
  input logic              start,
  input logic              busy,
  input logic              done,
  input logic              cfg_valid,
  input logic              cfg_ready,
  input ttc_pkg::reg_idx_t cfg_index
);

  // A result is only shown once the sequencer is back to idle
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobe while busy");

  // An accepted transaction either completes at once or keeps the block busy
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy || done))
    else $error("accepted transaction neither busy nor done");

  // A geometry write starts a fill pass and drops any pending result
  a_refill_busy: assert property (@(posedge clk) disable iff (rst)
    (cfg_valid && cfg_ready &&
     (cfg_index == ttc_pkg::REG_WIDTH || cfg_index == ttc_pkg::REG_HEIGHT))
    |=> (busy && !done))
    else $error("geometry write did not start a fill pass");

  // Reset leaves the block in its fill pass
  a_reset_fill: assert property (@(posedge clk) disable iff (rst)
    $fell(rst) |-> (busy && !done))
    else $error("no fill pass after reset");

endmodule

bind tty_text_console_core ttc_checker u_ttc_checker (.*);
